// ===== design/mtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Message tag manager package
// Shared constants, codes and helpers for the mailbox tag manager.
// ----------------------------------------------------------------------------
package mtm_pkg;

  // Tag pool: tag 0 is reserved, tags 1..NumTags-1 are handed out
  localparam int NumTags = 16;
  localparam int TagW    = $clog2(NumTags);
  localparam int CntW    = $clog2(NumTags);

  // Field widths
  localparam int MsgW    = 64;
  localparam int EpW     = 8;
  localparam int RelW    = 6;
  localparam int ActW    = 2;
  localparam int StatW   = 3;
  localparam int KindW   = 2;
  localparam int ChanW   = 8;
  localparam int PayW    = 32;
  localparam int TagFldW = 6;

  // Stream word widths (packed fields padded to whole bytes)
  localparam int InRawW  = MsgW + EpW + RelW;
  localparam int InDataW = ((InRawW + 7) / 8) * 8;
  localparam int OutRawW = StatW + TagW + MsgW + ChanW + PayW;
  localparam int OutDataW = ((OutRawW + 7) / 8) * 8;

  // Message field positions
  localparam int TagLsb  = 8;
  localparam int TypeLsb = 16;
  localparam int PayLsb  = 32;

  // Actions
  localparam logic [ActW-1:0] ActSend    = 2'd0;
  localparam logic [ActW-1:0] ActReceive = 2'd1;
  localparam logic [ActW-1:0] ActRelease = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] StOk       = 3'd0;
  localparam logic [StatW-1:0] StBusy     = 3'd1;
  localparam logic [StatW-1:0] StUnknown  = 3'd2;
  localparam logic [StatW-1:0] StBadTag   = 3'd3;
  localparam logic [StatW-1:0] StBadChan  = 3'd4;
  localparam logic [StatW-1:0] StNotAlloc = 3'd5;

  // Result kinds
  localparam logic [KindW-1:0] KindSent   = 2'd0;
  localparam logic [KindW-1:0] KindAck    = 2'd1;
  localparam logic [KindW-1:0] KindNack   = 2'd2;
  localparam logic [KindW-1:0] KindReport = 2'd3;

  // Link endpoint and message types
  localparam logic [EpW-1:0] LinkEp      = 8'h20;
  localparam logic [7:0]     TypeAck     = 8'h65;
  localparam logic [7:0]     TypeNack    = 8'h66;
  localparam logic [7:0]     TypeStarted = 8'h67;
  localparam logic [7:0]     TypeReport  = 8'h68;

  localparam logic [ChanW-1:0] NumChanRst = 8'd128;

  // Round-robin successor within 1..NumTags-1
  function automatic logic [TagW-1:0] next_tag(input logic [TagW-1:0] t);
    logic [TagW-1:0] r;
    if (t == TagW'(NumTags - 1)) begin
      r = TagW'(1);
    end else begin
      r = t + TagW'(1);
    end
    return r;
  endfunction

endpackage

// ===== design/message_tag_manager_core.sv =====
// ----------------------------------------------------------------------------
// Message tag manager core
// Allocates round-robin request tags for outgoing mailbox messages, decodes
// incoming messages and releases tags on ack, nack, started or release.
// ----------------------------------------------------------------------------
//
//  channel   | direction | word contents (low bit first)
//  ----------+-----------+-----------------------------------------------
//  s_axis    | in        | tdata: message, endpoint, release_tag; tuser: action
//  m_axis    | out       | tdata: status, tag_out, message_out, channel,
//            |           |        payload; tuser: kind
//  cfg       | in        | num_channels write
//
//  Receive and release finish in a single ST_EXEC step; a send checks one
//  tag per cycle in ST_SCAN through the shared tag-table lookup, up to
//  NumTags-1 tags. The input is ready only while the sequencer is idle; a
//  result waits in the output register, and the sequencer holds on every
//  step while that register is full and not taken. Reset clears the tag
//  table, the round-robin pointer and sets num_channels to 128.
//
module message_tag_manager_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // message[63:0], endpoint[71:64], release_tag[77:72], zero pad
  input  logic [mtm_pkg::InDataW-1:0]   s_axis_tdata,
  // action[1:0]
  input  logic [mtm_pkg::ActW-1:0]      s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[2:0], tag_out[6:3], message_out[70:7], channel[78:71],
  // payload[110:79], zero pad
  output logic [mtm_pkg::OutDataW-1:0]  m_axis_tdata,
  // kind[1:0]
  output logic [mtm_pkg::KindW-1:0]     m_axis_tuser,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mtm_pkg::ChanW-1:0]     cfg_data_i
);
  import mtm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC
  } state_e;

  state_e               state_q, state_d;
  logic [ActW-1:0]      act_q, act_d;
  logic [MsgW-1:0]      msg_q, msg_d;
  logic [EpW-1:0]       ep_q, ep_d;
  logic [RelW-1:0]      rel_q, rel_d;
  logic [TagW-1:0]      scan_tag_q, scan_tag_d;
  logic [CntW-1:0]      scan_cnt_q, scan_cnt_d;
  logic [NumTags-1:0]   tag_used_q, tag_used_d;
  logic [TagW-1:0]      last_tag_q, last_tag_d;
  logic [ChanW-1:0]     num_ch_q, num_ch_d;

  logic                 out_valid_q, out_valid_d;
  logic [StatW-1:0]     out_status_q, out_status_d;
  logic [KindW-1:0]     out_kind_q, out_kind_d;
  logic [TagW-1:0]      out_tag_q, out_tag_d;
  logic [MsgW-1:0]      out_msg_q, out_msg_d;
  logic [ChanW-1:0]     out_chan_q, out_chan_d;
  logic [PayW-1:0]      out_pay_q, out_pay_d;

  logic                 in_fire;
  logic                 out_free;
  logic [TagW-1:0]      lk_idx;
  logic                 lk_used;
  logic [TagFldW-1:0]   rx_tag;
  logic [7:0]           rx_type;
  logic [ChanW-1:0]     rx_chan;
  logic [PayW-1:0]      rx_pay;
  logic                 rx_is_ack;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Message decode
  assign rx_tag    = msg_q[TagLsb +: TagFldW];
  assign rx_type   = msg_q[TypeLsb +: 8];
  assign rx_chan   = msg_q[ChanW-1:0];
  assign rx_pay    = msg_q[PayLsb +: PayW];
  assign rx_is_ack = (rx_type == TypeAck) || (rx_type == TypeNack) ||
                     (rx_type == TypeStarted);

  // Shared tag-table lookup
  always_comb begin
    if (state_q == ST_SCAN) begin
      lk_idx = scan_tag_q;
    end else if (act_q == ActReceive) begin
      lk_idx = rx_tag[TagW-1:0];
    end else begin
      lk_idx = rel_q[TagW-1:0];
    end
  end
  assign lk_used = tag_used_q[lk_idx];

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    msg_d        = msg_q;
    ep_d         = ep_q;
    rel_d        = rel_q;
    scan_tag_d   = scan_tag_q;
    scan_cnt_d   = scan_cnt_q;
    tag_used_d   = tag_used_q;
    last_tag_d   = last_tag_q;
    num_ch_d     = num_ch_q;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_status_d = out_status_q;
    out_kind_d   = out_kind_q;
    out_tag_d    = out_tag_q;
    out_msg_d    = out_msg_q;
    out_chan_d   = out_chan_q;
    out_pay_d    = out_pay_q;

    if (cfg_valid_i) begin
      num_ch_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          act_d      = s_axis_tuser;
          msg_d      = s_axis_tdata[MsgW-1:0];
          ep_d       = s_axis_tdata[MsgW +: EpW];
          rel_d      = s_axis_tdata[MsgW+EpW +: RelW];
          scan_tag_d = next_tag(last_tag_q);
          scan_cnt_d = '0;
          if (s_axis_tuser == ActSend) begin
            state_d = ST_SCAN;
          end else if (s_axis_tuser == ActReceive || s_axis_tuser == ActRelease) begin
            state_d = ST_EXEC;
          end
        end
      end

      // one tag checked per cycle while the output register can take a result
      ST_SCAN: begin
        if (out_free) begin
          if (!lk_used) begin
            tag_used_d[scan_tag_q] = 1'b1;
            last_tag_d   = scan_tag_q;
            out_valid_d  = 1'b1;
            out_status_d = StOk;
            out_kind_d   = KindSent;
            out_tag_d    = scan_tag_q;
            out_msg_d    = msg_q;
            out_msg_d[TagLsb +: TagFldW] = TagFldW'(scan_tag_q);
            out_chan_d   = rx_chan;
            out_pay_d    = '0;
            state_d      = ST_IDLE;
          end else if (scan_cnt_q == CntW'(NumTags - 2)) begin
            // full lap without a free tag; pointer still steps by one
            last_tag_d   = next_tag(scan_tag_q);
            out_valid_d  = 1'b1;
            out_status_d = StBusy;
            out_kind_d   = KindSent;
            out_tag_d    = '0;
            out_msg_d    = '0;
            out_chan_d   = rx_chan;
            out_pay_d    = '0;
            state_d      = ST_IDLE;
          end else begin
            scan_tag_d = next_tag(scan_tag_q);
            scan_cnt_d = scan_cnt_q + CntW'(1);
          end
        end
      end

      // receive or release, single step
      ST_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_msg_d   = '0;
          state_d     = ST_IDLE;
          if (act_q == ActReceive) begin
            out_chan_d   = rx_chan;
            out_pay_d    = rx_pay;
            out_status_d = StUnknown;
            out_kind_d   = KindSent;
            out_tag_d    = '0;
            if (ep_q == LinkEp) begin
              if (rx_is_ack) begin
                out_kind_d = (rx_type == TypeNack) ? KindNack : KindAck;
                out_tag_d  = rx_tag[TagW-1:0];
                if (rx_tag >= TagFldW'(NumTags)) begin
                  out_status_d = StBadTag;
                end else if (!lk_used) begin
                  out_status_d = StNotAlloc;
                end else begin
                  tag_used_d[lk_idx] = 1'b0;
                  out_status_d = StOk;
                end
              end else if (rx_type == TypeReport) begin
                out_kind_d   = KindReport;
                out_status_d = (rx_chan >= num_ch_q) ? StBadChan : StOk;
              end
            end
          end else begin
            out_chan_d = '0;
            out_pay_d  = '0;
            out_kind_d = KindSent;
            out_tag_d  = rel_q[TagW-1:0];
            if (rel_q >= RelW'(NumTags)) begin
              out_status_d = StBadTag;
            end else if (!lk_used) begin
              out_status_d = StNotAlloc;
            end else begin
              tag_used_d[lk_idx] = 1'b0;
              out_status_d = StOk;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tag_used_q  <= '0;
      last_tag_q  <= '0;
      num_ch_q    <= NumChanRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tag_used_q  <= tag_used_d;
      last_tag_q  <= last_tag_d;
      num_ch_q    <= num_ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    msg_q        <= msg_d;
    ep_q         <= ep_d;
    rel_q        <= rel_d;
    scan_tag_q   <= scan_tag_d;
    scan_cnt_q   <= scan_cnt_d;
    out_status_q <= out_status_d;
    out_kind_q   <= out_kind_d;
    out_tag_q    <= out_tag_d;
    out_msg_q    <= out_msg_d;
    out_chan_q   <= out_chan_d;
    out_pay_q    <= out_pay_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {{(OutDataW - OutRawW){1'b0}}, out_pay_q, out_chan_q,
                          out_msg_q, out_tag_q, out_status_q};

endmodule

// ===== sim/tb_message_tag_manager_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Message tag manager core testbench
// Drives send, receive and release words through the input stream and
// checks every result word against a cycle-free model of the tag pool.
// Directed tests cover pool exhaustion, inbound decode, tag release and the
// channel limit. Random traffic with bursty input and a stalling output
// follows, under several channel limits.
// ----------------------------------------------------------------------------
module tb_message_tag_manager_core;
  import mtm_pkg::*;

  localparam int ClkPeriod  = 20;
  localparam int DrainWait  = 40;
  localparam int IdleLimit  = 1000;
  localparam int RandWords  = 1500;

  // Unused action code, dropped by the core
  localparam logic [ActW-1:0] ActNone = 2'd3;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  tag;
    logic [MsgW-1:0]  msg;
    logic [ChanW-1:0] chan;
    logic [PayW-1:0]  payload;
  } tag_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [ActW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [ChanW-1:0]    cfg_data_i;

  // Model state of the tag pool and the channel register
  logic [NumTags-1:0]  tags_busy;
  logic [TagW-1:0]     rr_tag;
  logic [ChanW-1:0]    chan_limit;

  tag_result_t         pending_results[$];
  int                  error_count;
  int                  burst_left;
  int                  send_pct;
  int                  stall_mode;
  int                  stall_cnt;
  int                  idle_cycles;

  message_tag_manager_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Round-robin step over tags 1..NumTags-1
  function automatic logic [TagW-1:0] rr_successor(input logic [TagW-1:0] t);
    if (t == TagW'(NumTags - 1)) begin
      return TagW'(1);
    end
    return t + TagW'(1);
  endfunction

  // Expected result of one accepted word; updates the pool model.
  // Returns 0 for a word that yields no result.
  function automatic bit predict_tag_result(input logic [ActW-1:0] act,
                                            input logic [MsgW-1:0] msg,
                                            input logic [EpW-1:0] ep,
                                            input logic [RelW-1:0] rel,
                                            output tag_result_t res);
    logic [TagW-1:0]    t;
    logic [7:0]         mtype;
    logic [TagFldW-1:0] mtag;
    bit                 found;
    res   = '0;
    found = 1'b0;
    mtype = msg[TypeLsb +: 8];
    mtag  = msg[TagLsb +: TagFldW];
    res.chan = msg[ChanW-1:0];
    case (act)
      ActSend: begin
        t = rr_successor(rr_tag);
        for (int i = 0; i < NumTags - 1; i++) begin
          if (!found) begin
            if (!tags_busy[t]) begin
              tags_busy[t] = 1'b1;
              found = 1'b1;
            end else begin
              t = rr_successor(t);
            end
          end
        end
        rr_tag = t;
        if (found) begin
          res.status = StOk;
          res.tag    = t;
          res.msg    = {msg[MsgW-1:TagLsb+TagFldW], (TagFldW - TagW)'(0), t,
                        msg[TagLsb-1:0]};
        end else begin
          res.status = StBusy;
        end
        return 1'b1;
      end
      ActReceive: begin
        res.payload = msg[MsgW-1:PayLsb];
        res.kind    = KindSent;
        res.status  = StUnknown;
        if (ep == LinkEp) begin
          if (mtype == TypeAck || mtype == TypeNack || mtype == TypeStarted) begin
            res.kind = (mtype == TypeNack) ? KindNack : KindAck;
            res.tag  = mtag[TagW-1:0];
            if (mtag >= NumTags) begin
              res.status = StBadTag;
            end else if (!tags_busy[mtag[TagW-1:0]]) begin
              res.status = StNotAlloc;
            end else begin
              tags_busy[mtag[TagW-1:0]] = 1'b0;
              res.status = StOk;
            end
          end else if (mtype == TypeReport) begin
            res.kind   = KindReport;
            res.status = (msg[ChanW-1:0] >= chan_limit) ? StBadChan : StOk;
          end
        end
        return 1'b1;
      end
      ActRelease: begin
        res.chan = '0;
        res.tag  = rel[TagW-1:0];
        if (rel >= NumTags) begin
          res.status = StBadTag;
        end else if (!tags_busy[rel[TagW-1:0]]) begin
          res.status = StNotAlloc;
        end else begin
          tags_busy[rel[TagW-1:0]] = 1'b0;
          res.status = StOk;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Inbound message: payload and spare bits random, type/tag/channel given
  function automatic logic [MsgW-1:0] make_rx(input logic [7:0] mtype,
                                              input logic [TagFldW-1:0] tag,
                                              input logic [ChanW-1:0] chan);
    return {32'($urandom), 8'($urandom), mtype, 2'($urandom), tag, chan};
  endfunction

  function automatic logic [MsgW-1:0] rand_msg();
    return {32'($urandom), 32'($urandom)};
  endfunction

  // A tag currently held in the model, or any tag when none is held
  function automatic logic [TagFldW-1:0] pick_live_tag();
    logic [TagW-1:0] cand[$];
    for (int i = 1; i < NumTags; i++) begin
      if (tags_busy[i]) cand.push_back(TagW'(i));
    end
    if (cand.size() == 0) return TagFldW'($urandom_range(0, NumTags - 1));
    return TagFldW'(cand[$urandom_range(0, cand.size() - 1)]);
  endfunction

  // Send one input word, honoring the burst/gap pattern
  task automatic push_word(input logic [ActW-1:0] act, input logic [MsgW-1:0] msg,
                           input logic [EpW-1:0] ep, input logic [RelW-1:0] rel);
    int          gap;
    tag_result_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({rel, ep, msg});
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_tag_result(act, msg, ep, rel, res)) begin
      pending_results.push_back(res);
    end
  endtask

  // Channel limit write, only with the core drained
  task automatic write_channel_limit(input logic [ChanW-1:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // ignored words leave no result behind; give the core time to settle
    repeat (DrainWait) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    chan_limit = value;
  endtask

  // Fill the pool, then two sends that find no free tag
  task automatic test_tag_exhaustion();
    push_word(ActSend, '0, '0, '0);
    push_word(ActSend, '1, '1, '1);
    for (int i = 0; i < NumTags - 3; i++) begin
      push_word(ActSend, rand_msg(), 8'($urandom), 6'($urandom));
    end
    push_word(ActSend, rand_msg(), '0, '0);
    push_word(ActSend, '1, '0, '0);
  endtask

  // Ack, nack, started, report and the decode error paths
  task automatic test_inbound_decode();
    push_word(ActReceive, make_rx(TypeAck, 6'd3, 8'hff), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeNack, 6'd7, 8'h00), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeStarted, 6'd12, 8'd200), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeAck, 6'd3, 8'd1), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeAck, 6'd0, 8'd1), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeNack, 6'd63, 8'd2), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeAck, 6'd16, 8'd2), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeAck, 6'd5, 8'd3), 8'hff, '0);
    push_word(ActReceive, make_rx(TypeAck, 6'd5, 8'd3), 8'h00, '0);
    push_word(ActReceive, make_rx(8'h64, 6'd5, 8'd4), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeReport, 6'd9, 8'd127), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeReport, 6'd0, 8'd128), LinkEp, '0);
    push_word(ActSend, rand_msg(), '0, '0);
  endtask

  task automatic test_tag_release();
    push_word(ActRelease, rand_msg(), 8'($urandom), 6'd5);
    push_word(ActRelease, rand_msg(), 8'($urandom), 6'd5);
    push_word(ActRelease, '0, '0, 6'd16);
    push_word(ActRelease, '1, '1, 6'd63);
    push_word(ActRelease, '0, '0, 6'd0);
  endtask

  // Unused action code yields nothing; the following send must line up
  task automatic test_ignored_action();
    push_word(ActNone, rand_msg(), LinkEp, 6'd1);
    push_word(ActSend, rand_msg(), '0, '0);
  endtask

  task automatic test_channel_limit();
    write_channel_limit(8'd1);
    push_word(ActReceive, make_rx(TypeReport, 6'd0, 8'd0), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeReport, 6'd0, 8'd1), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeReport, 6'd0, 8'd255), LinkEp, '0);
    write_channel_limit(NumChanRst);
    push_word(ActReceive, make_rx(TypeReport, 6'd0, 8'd127), LinkEp, '0);
    push_word(ActReceive, make_rx(TypeReport, 6'd0, 8'd128), LinkEp, '0);
  endtask

  // Mostly well-formed traffic against the live pool, some noise
  task automatic test_random_traffic();
    logic [ChanW-1:0] limits[5];
    logic [7:0]       mtype;
    logic [ChanW-1:0] chan;
    int               sent;
    int               r;
    limits[0] = 8'd1;
    limits[1] = NumChanRst;
    limits[2] = 8'($urandom_range(2, 127));
    limits[3] = 8'($urandom_range(1, 16));
    limits[4] = NumChanRst;
    for (int ph = 0; ph < 5; ph++) begin
      write_channel_limit(limits[ph]);
      send_pct = $urandom_range(25, 60);
      sent = 0;
      while (sent < RandWords / 5) begin
        sent++;
        if ($urandom_range(0, 99) < send_pct) begin
          push_word(ActSend, ($urandom_range(0, 15) == 0) ? '1 : rand_msg(),
                    8'($urandom), 6'($urandom));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 55) begin
            case ($urandom_range(0, 2))
              0:       mtype = TypeAck;
              1:       mtype = TypeNack;
              default: mtype = TypeStarted;
            endcase
            push_word(ActReceive, make_rx(mtype, pick_live_tag(), 8'($urandom)),
                      LinkEp, 6'($urandom));
          end else if (r < 70) begin
            case ($urandom_range(0, 2))
              0:       chan = chan_limit - 8'd1;
              1:       chan = chan_limit;
              default: chan = 8'($urandom);
            endcase
            push_word(ActReceive, make_rx(TypeReport, 6'($urandom), chan), LinkEp,
                      6'($urandom));
          end else if (r < 80) begin
            push_word(ActRelease, rand_msg(), 8'($urandom), pick_live_tag());
          end else if (r < 88) begin
            mtype = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h64, 8'h69))
                                                : 8'($urandom);
            push_word(ActReceive, make_rx(mtype, 6'($urandom), 8'($urandom)),
                      ($urandom_range(0, 1) == 0) ? LinkEp : 8'($urandom),
                      6'($urandom));
          end else if (r < 94) begin
            push_word(ActRelease, rand_msg(), 8'($urandom), 6'($urandom));
          end else if (r < 97) begin
            // ignored word, not counted
            push_word(ActNone, rand_msg(), 8'($urandom), 6'($urandom));
            sent--;
          end else begin
            push_word(ActReceive, rand_msg(), 8'($urandom), 6'($urandom));
          end
        end
      end
    end
  endtask

  // Result field compare
  function automatic void check_field(input string fname, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v,
               act_v);
      error_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    tag_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected, actual %0h", $time,
                 m_axis_tdata);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 64'(exp_r.status), 64'(m_axis_tdata[2:0]));
        check_field("tag_out", 64'(exp_r.tag), 64'(m_axis_tdata[6:3]));
        check_field("message_out", exp_r.msg, m_axis_tdata[70:7]);
        check_field("channel", 64'(exp_r.chan), 64'(m_axis_tdata[78:71]));
        check_field("payload", 64'(exp_r.payload), 64'(m_axis_tdata[110:79]));
        check_field("kind", 64'(exp_r.kind), 64'(m_axis_tuser));
      end
    end
  end

  // Output backpressure: free-running, random, sparse and long-stall modes
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_cnt  <= $urandom_range(20, 200);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
      2:       m_axis_tready <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready <= (stall_cnt % 16 == 0);
    endcase
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    tags_busy     = '0;
    rr_tag        = '0;
    chan_limit    = NumChanRst;
    error_count   = 0;
    burst_left    = 0;
    stall_mode    = 0;
    stall_cnt     = 0;
    idle_cycles   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tag_exhaustion();
    test_inbound_decode();
    test_tag_release();
    test_ignored_action();
    test_channel_limit();
    test_random_traffic();

    // drain
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
